// File: hdl/hpt_pkg.sv
// hpt_pkg: shared constants for the homogeneous point transform
// holds the matrix register file geometry used by the top level and the testbench; the divider lane imports it too
// no dependencies
`default_nettype none

package hpt_pkg;

  // matrix entries are signed fixed point, always 32 bits
  localparam int ENTRY_WIDTH = 32;
  // each register holds one pair of entries
  localparam int REG_WIDTH   = 2 * ENTRY_WIDTH;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  // byte address of register i is 8*i
  localparam int ADDR_WIDTH  = REG_IDX_W + 3;
  // rows and columns of the matrix
  localparam int MAT_DIM     = 4;
  // number of transformed coordinates (x, y, z)
  localparam int NUM_COORDS  = 3;

endpackage

`default_nettype wire

// File: hdl/homogeneous_point_transform.sv
// homogeneous_point_transform: 4x4 matrix times (x,y,z,1), then divide by W
// one point accepted per cycle while the output is not stalled
// most of the pipeline is in the divider lanes, one quotient bit per stage
// a stall on the output freezes the whole pipeline in place
// reset clears all valid bits and loads the identity matrix
`default_nettype none

module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_WIDTH-1:0]         paddr,
  input  wire logic [REG_WIDTH-1:0]          pwdata,
  output logic      [REG_WIDTH-1:0]          prdata,
  output logic                               pready,
  // point input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic signed [COORD_WIDTH-1:0]      out_z_o,
  output logic                               w_was_zero_o,
  output logic                               saturated_o
);

  localparam int PW  = ENTRY_WIDTH + COORD_WIDTH;
  localparam int TW  = ENTRY_WIDTH + FRACTION_BITS;
  localparam int SW  = ((PW > TW) ? PW : TW) + 2;
  localparam int NST = COORD_WIDTH + 1;
  localparam logic [ENTRY_WIDTH-1:0] ONE = ENTRY_WIDTH'(1) << FRACTION_BITS;

  logic                  en;
  logic [REG_WIDTH-1:0]  cfg_q [NUM_REGS];
  logic signed [ENTRY_WIDTH-1:0] m [MAT_DIM][MAT_DIM];

  // configuration registers
  function automatic logic [REG_WIDTH-1:0] reset_value(input int idx);
    logic [REG_WIDTH-1:0] v;
    v = '0;
    if (idx == 0 || idx == 5) v = {ONE, {ENTRY_WIDTH{1'b0}}};
    if (idx == 2 || idx == 7) v = {{ENTRY_WIDTH{1'b0}}, ONE};
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= reset_value(i);
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[ADDR_WIDTH-1:3]] <= pwdata;
    end
  end

  assign prdata = cfg_q[paddr[ADDR_WIDTH-1:3]];
  assign pready = 1'b1;

  // matrix entries out of the register pairs
  for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
    for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
      localparam int TOP = ((c % 2) == 0) ? REG_WIDTH : ENTRY_WIDTH;
      assign m[r][c] = cfg_q[r*2 + c/2][TOP-1 -: ENTRY_WIDTH];
    end
  end

  // whole pipeline advances unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: register the point
  logic                          v1_q;
  logic signed [COORD_WIDTH-1:0] p_q [NUM_COORDS];

  // stage 2: products and translation terms
  logic                          v2_q;
  logic signed [PW-1:0]          prod_q  [MAT_DIM][NUM_COORDS];
  logic signed [TW-1:0]          trans_q [MAT_DIM];

  // stage 3: exact row sums
  logic                          v3_q;
  logic signed [SW-1:0]          sum_q [MAT_DIM];

  // stage 4: magnitudes and signs
  logic                          v4_q;
  logic                          wz4_q;
  logic [SW-1:0]                 num_abs_q [NUM_COORDS];
  logic [SW-1:0]                 den_abs_q;
  logic                          neg4_q [NUM_COORDS];

  // side line along the divider lanes
  logic                          sv_q   [NST];
  logic                          swz_q  [NST];
  logic [NUM_COORDS-1:0]         sneg_q [NST];

  // divider results
  logic [COORD_WIDTH-1:0]        quot [NUM_COORDS];
  logic                          ovf  [NUM_COORDS];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      for (int k = 0; k < NST; k++) sv_q[k] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      sv_q[0]     <= v4_q;
      for (int k = 1; k < NST; k++) sv_q[k] <= sv_q[k-1];
      out_valid_o <= sv_q[NST-1];
    end
  end

  // arithmetic stages ahead of the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= in_x_i;
      p_q[1] <= in_y_i;
      p_q[2] <= in_z_i;
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < NUM_COORDS; c++) prod_q[r][c] <= m[r][c] * p_q[c];
        trans_q[r] <= {m[r][3], {FRACTION_BITS{1'b0}}};
        sum_q[r]   <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
                    + SW'(trans_q[r]);
      end
      for (int i = 0; i < NUM_COORDS; i++) begin
        num_abs_q[i] <= sum_q[i][SW-1] ? SW'(-sum_q[i]) : SW'(sum_q[i]);
        neg4_q[i]    <= sum_q[i][SW-1] ^ sum_q[3][SW-1];
      end
      den_abs_q <= sum_q[3][SW-1] ? SW'(-sum_q[3]) : SW'(sum_q[3]);
      wz4_q     <= (sum_q[3] == '0);
    end
  end

  // side line payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      swz_q[0]  <= wz4_q;
      sneg_q[0] <= {neg4_q[2], neg4_q[1], neg4_q[0]};
      for (int k = 1; k < NST; k++) begin
        swz_q[k]  <= swz_q[k-1];
        sneg_q[k] <= sneg_q[k-1];
      end
    end
  end

  // one divider lane per coordinate
  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_lane
    hpt_div_lane #(
      .SUM_WIDTH  (SW),
      .QUOT_WIDTH (COORD_WIDTH),
      .FRAC_BITS  (FRACTION_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_abs_q[i]),
      .den_i  (den_abs_q),
      .quot_o (quot[i]),
      .ovf_o  (ovf[i])
    );
  end

  // saturate and restore sign; a zero W is zeroed in the output register
  logic [COORD_WIDTH-1:0] res [NUM_COORDS];
  logic [NUM_COORDS-1:0]  lane_sat;

  always_comb begin
    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] mag;
    for (int i = 0; i < NUM_COORDS; i++) begin
      lim         = sneg_q[NST-1][i] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      lane_sat[i] = ovf[i] || (quot[i] > lim);
      mag         = lane_sat[i] ? lim : quot[i];
      res[i]      = sneg_q[NST-1][i] ? COORD_WIDTH'(-mag) : mag;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (swz_q[NST-1]) begin
        out_x_o     <= '0;
        out_y_o     <= '0;
        out_z_o     <= '0;
        saturated_o <= 1'b0;
      end else begin
        out_x_o     <= res[0];
        out_y_o     <= res[1];
        out_z_o     <= res[2];
        saturated_o <= |lane_sat;
      end
      w_was_zero_o <= swz_q[NST-1];
    end
  end

  // a stall freezes the valid line
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v2_q) && $stable(v4_q) && $stable(sv_q[NST-1]))
    else $error("pipeline valid moved during stall");

  // a register write lands in the addressed pair
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> prdata == $past(pwdata) || paddr != $past(paddr))
    else $error("configuration write lost");

  // a zero W gives zero coordinates and no clamp
  a_wzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_was_zero_o |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0
      && !saturated_o)
    else $error("zero W result not cleared");

endmodule

`default_nettype wire

// File: hdl/hpt_div_lane.sv
// hpt_div_lane: pipelined restoring divider, one quotient bit per stage
// computes (num << FRAC_BITS) / den on magnitudes, with an overflow flag
// imports hpt_pkg but uses none of its constants
`default_nettype none

module hpt_div_lane import hpt_pkg::*; #(
  parameter int SUM_WIDTH  = 66,
  parameter int QUOT_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [SUM_WIDTH-1:0]  num_i,
  input  wire logic [SUM_WIDTH-1:0]  den_i,
  output logic      [QUOT_WIDTH-1:0] quot_o,
  output logic                       ovf_o
);

  localparam int NW   = SUM_WIDTH + FRAC_BITS;
  localparam int HW   = NW - QUOT_WIDTH;
  localparam int CMPW = (HW > SUM_WIDTH) ? HW : SUM_WIDTH;
  localparam int NST  = QUOT_WIDTH + 1;

  logic [NW-1:0]         num_sh;
  logic [HW-1:0]         num_hi;
  logic                  ovf0;

  logic [SUM_WIDTH-1:0]  rem_q  [NST];
  logic [SUM_WIDTH-1:0]  den_q  [NST];
  logic [QUOT_WIDTH-1:0] low_q  [NST];
  logic [QUOT_WIDTH-1:0] quo_q  [NST];
  logic                  ovf_q  [NST];

  // scaled numerator and its part above the quotient bits
  assign num_sh = {num_i, {FRAC_BITS{1'b0}}};
  assign num_hi = num_sh[NW-1:QUOT_WIDTH];
  // quotient would need more than QUOT_WIDTH bits
  assign ovf0   = CMPW'(num_hi) >= CMPW'(den_i);

  // entry stage: seed the partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf0 ? '0 : SUM_WIDTH'(num_hi);
      den_q[0] <= den_i;
      low_q[0] <= num_sh[QUOT_WIDTH-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf0;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [SUM_WIDTH:0] trial;
    logic               ge;

    assign trial = {rem_q[k-1], low_q[k-1][QUOT_WIDTH-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? SUM_WIDTH'(trial - {1'b0, den_q[k-1]}) : SUM_WIDTH'(trial);
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][QUOT_WIDTH-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QUOT_WIDTH-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quo_q[NST-1];
  assign ovf_o  = ovf_q[NST-1];

endmodule

`default_nettype wire

// File: tb/homogeneous_point_transform_checker.sv
// homogeneous_point_transform_checker: watches the config, input and output channels
// predicts each transformed point and compares it with the block's result
// depends on hpt_pkg for register geometry
`timescale 1ns / 100ps

module homogeneous_point_transform_checker import hpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [REG_WIDTH-1:0]  pwdata,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic [31:0]           in_x_i,
  input  logic [31:0]           in_y_i,
  input  logic [31:0]           in_z_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [31:0]           out_x_o,
  input  logic [31:0]           out_y_o,
  input  logic [31:0]           out_z_o,
  input  logic                  w_was_zero_o,
  input  logic                  saturated_o,
  output int                    fail_count,
  output int                    pending_count
);

  localparam int FRAC = 16;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } point_res_t;

  logic [REG_WIDTH-1:0] matrix_regs [NUM_REGS];
  point_res_t           expected_points [$];

  function automatic logic signed [31:0] mat_entry(int r, int c);
    logic [63:0] rv;
    rv = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? rv[31:0] : rv[63:32];
  endfunction

  // exact row sum at scale 2^(2*FRAC)
  function automatic logic signed [127:0] row_acc(int r, logic signed [31:0] p [3]);
    logic signed [127:0] acc;
    acc = 128'(signed'(mat_entry(r, 3))) <<< FRAC;
    for (int c = 0; c < 3; c++)
      acc += 128'(signed'(mat_entry(r, c))) * 128'(signed'(p[c]));
    return acc;
  endfunction

  // truncating divide with clamp to 32-bit signed range
  function automatic logic [31:0] div_clamp(logic signed [127:0] num,
                                            logic signed [127:0] den, ref logic sat);
    logic        neg;
    logic [127:0] an, ad, q, lim;
    neg = num[127] ^ den[127];
    an  = num[127] ? -num : num;
    ad  = den[127] ? -den : den;
    q   = (an << FRAC) / ad;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic point_res_t transform_point(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
    logic signed [31:0]  p [3];
    logic signed [127:0] s [4];
    point_res_t          r;
    logic                sat;
    p[0] = x; p[1] = y; p[2] = z;
    for (int i = 0; i < 4; i++) s[i] = row_acc(i, p);
    r = '0;
    if (s[3] == 0) begin
      r.wz = 1'b1;
      return r;
    end
    sat = 1'b0;
    r.x = div_clamp(s[0], s[3], sat);
    r.y = div_clamp(s[1], s[3], sat);
    r.z = div_clamp(s[2], s[3], sat);
    r.sat = sat;
    return r;
  endfunction

  assign pending_count = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_res_t e;
    if (!rst_ni) begin
      matrix_regs[0] <= 64'h0001_0000_0000_0000;
      matrix_regs[1] <= '0;
      matrix_regs[2] <= 64'h0000_0000_0001_0000;
      matrix_regs[3] <= '0;
      matrix_regs[4] <= '0;
      matrix_regs[5] <= 64'h0001_0000_0000_0000;
      matrix_regs[6] <= '0;
      matrix_regs[7] <= 64'h0000_0000_0001_0000;
      fail_count     <= 0;
    end else begin
      // register write transfer
      if (psel && penable && pwrite && pready)
        matrix_regs[paddr[ADDR_WIDTH-1:3]] <= pwdata;
      // input transfer
      if (in_valid_i && in_ready_o)
        expected_points.push_back(transform_point(in_x_i, in_y_i, in_z_i));
      // output transfer
      if (out_valid_o && out_ready_i) begin
        if (expected_points.size() == 0) begin
          if (fail_count < 10) $display("unexpected result x=%h", out_x_o);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_points.pop_front();
          if (e.x !== out_x_o || e.y !== out_y_o || e.z !== out_z_o ||
              e.wz !== w_was_zero_o || e.sat !== saturated_o) begin
            if (fail_count < 10)
              $display("mismatch exp %h %h %h wz=%b sat=%b got %h %h %h wz=%b sat=%b",
                       e.x, e.y, e.z, e.wz, e.sat, out_x_o, out_y_o, out_z_o,
                       w_was_zero_o, saturated_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/homogeneous_point_transform_tb.sv
// homogeneous_point_transform_tb: stimulus and verdict for the point transform
// drives config writes and points, checking is in homogeneous_point_transform_checker
// depends on hpt_pkg and the block's rtl
`timescale 1ns / 100ps

module homogeneous_point_transform_tb import hpt_pkg::*;;

  localparam int DRAIN  = 80;
  localparam int WD_MAX = 20000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [REG_WIDTH-1:0]  pwdata = '0;
  logic [REG_WIDTH-1:0]  prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0, in_ready_o;
  logic signed [31:0]    in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic                  out_valid_o, out_ready_i = 1'b0;
  logic signed [31:0]    out_x_o, out_y_o, out_z_o;
  logic                  w_was_zero_o, saturated_o;
  int                    fail_count, pending_count;
  int                    send_idle_pct = 0, recv_stall_pct = 0;
  bit                    hold_off = 1'b0;
  int                    idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  homogeneous_point_transform dut (.*);

  homogeneous_point_transform_checker chk (.*);

  // receiver: random stalls, or a long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_MAX) begin
      $display("homogeneous_point_transform test failed");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_WIDTH'(idx * 8); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays up across back-to-back transfers, drops only on idle cycles
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i <= x; in_y_i <= y; in_z_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // coordinates biased toward small fixed-point values, with some full-range words
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'h0001_0000;
      2: return 32'h0;
      default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic load_matrix(int kind);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        0: write_reg(i, {32'h8000_0000, 32'h7fff_ffff});
        1: write_reg(i, {32'hffff_ffff, 32'h0000_0000});
        default: write_reg(i, {rand_entry(), rand_entry()});
      endcase
    end
    // keep W nonzero most of the time: m32 gets a small entry and m33 = 1.0
    if (kind >= 2 && $urandom_range(3) != 0)
      write_reg(7, {32'($signed($urandom_range(1 << 10)) - (1 << 9)), 32'h0001_0000});
  endtask

  initial begin
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{85, 0}, '{0, 85}, '{15, 15}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix: unchanged coordinates, extremes of each field
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
    send_point(32'haaaa_5555, 32'h5555_aaaa, 32'hffff_ffff);
    drain_results();
    // row 3 all zero: W is zero
    write_reg(6, 64'h0);
    write_reg(7, 64'h0);
    send_point(32'h0001_0000, 32'h2, 32'h3);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain_results();
    // extreme matrices: overflow and saturation, negative W
    for (int k = 0; k < 2; k++) begin
      load_matrix(k);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff);
      drain_results();
    end
    // tiny W makes quotients blow up
    write_reg(6, 64'h0);
    write_reg(7, 64'h0000_0000_0000_0001);
    write_reg(0, {32'h0001_0000, 32'h0});
    send_point(32'h0010_0000, 32'h1, 32'hfff0_0000);
    send_point(32'hfff0_0000, 32'h0, 32'h0);
    drain_results();

    // random phases, each with a fresh matrix
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(2);
      send_idle_pct  = phase_pct[ph % 4][0];
      recv_stall_pct = phase_pct[ph % 4][1];
      for (int n = 0; n < 66; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (ph == 0 && n == 5) begin
          // long receiver hold-off so the pipeline fills and backs up
          fork
            begin
              int hold;
              hold_off = 1'b1;
              hold = 0;
              while (hold < 200) begin
                @(posedge clk_i);
                hold++;
              end
              hold_off = 1'b0;
            end
          join_none
        end
      end
      drain_results();
    end

    if (fail_count == 0)
      $display("homogeneous_point_transform test passed");
    else
      $display("homogeneous_point_transform test failed");
    $finish;
  end

endmodule
